[design/olid_pkg.sv]
// Shared types and codes for the ordered list block.
// No dependencies; every other design file but olid_prefix imports this package.
package olid_pkg;

  localparam int unsigned OPC_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [OPC_W-1:0] {
    OP_FRONT  = 2'd0,
    OP_BACK   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_DONE      = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  // one-hot sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic cmp;     // capture compare result
    logic front;   // shift towards the back, cell 0 takes the new value
    logic append;  // tail cell takes the new value
    logic remove;  // cells at or past the first hit take from their right
  } cell_cmd_t;

endpackage

[design/olid_req_if.sv]
// Request channel: opcode and value words, valid/ready handshake.
// Depends on olid_pkg for field widths.
interface olid_req_if;
  import olid_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

[design/olid_rsp_if.sv]
// Response channel: status and count words, valid/ready handshake.
// Depends on olid_pkg for field widths.
interface olid_rsp_if;
  import olid_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STS_W-1:0]     status;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

[design/ordered_list_insert_delete_top.sv]
// Ordered list top level: sequencer, occupancy and the row of cells.
// Depends on olid_pkg, olid_req_if, olid_rsp_if, olid_cell, olid_prefix.
//
//   channel | dir | word fields          | handshake
//   --------+-----+----------------------+-------------
//   req     | in  | opcode[1:0] value[31:0] | valid/ready
//   rsp     | out | status[1:0] count[6:0]  | valid/ready
//
// Each word is accepted, compared in every cell, then applied (shift or load);
//   the next word is not accepted until the sequencer is back in idle.
// The response sits in an output register; the next request is taken while
//   it waits, as long as it leaves in the same cycle.
// Reset clears sequencer, occupancy and response valid; entries are not
//   cleared, only positions below the occupancy are ever read.
// Stalls on rsp hold the register and block only the next accept.
module ordered_list_insert_delete_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  olid_req_if.sink   req,
  olid_rsp_if.source rsp
);
  import olid_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t                  state, state_next;
  op_t                     op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CNT_W-1:0]        occ, occ_next;
  logic                    rsp_valid;
  status_t                 rsp_status, sts_next;
  logic [CNT_OUT_W-1:0]    rsp_count;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]     hit, seen;
  logic                    full, empty, found;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  // row of cells, each wired to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_e, next_e;
    if (i == 0) begin : g_first
      assign prev_e = val_q;
    end else begin : g_mid
      assign prev_e = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry[i+1];
    end
    olid_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .value      (val_q),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .live       (occ > CNT_W'(i)),
      .tail       (occ == CNT_W'(i)),
      .kill       (seen[i]),
      .entry      (entry[i]),
      .hit        (hit[i])
    );
  end

  olid_prefix #(.N(CAPACITY)) u_prefix (
    .hit  (hit),
    .seen (seen)
  );

  assign full  = (occ == CNT_W'(CAPACITY));
  assign empty = (occ == '0);
  assign found = seen[CAPACITY-1];

  // sequencer next state, compare command and apply-stage decision
  always_comb begin
    cmd        = '0;
    cmd.cmp    = (state == ST_MATCH);
    occ_next   = occ;
    sts_next   = STS_DONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid && req.ready) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        state_next = ST_IDLE;
        case (op_q)
          OP_FRONT: begin
            if (full) begin
              sts_next = STS_FULL;
            end else begin
              cmd.front = 1'b1;
              occ_next  = occ + CNT_W'(1);
            end
          end
          OP_BACK: begin
            if (full) begin
              sts_next = STS_FULL;
            end else begin
              cmd.append = 1'b1;
              occ_next   = occ + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            if (empty) begin
              sts_next = STS_EMPTY;
            end else if (!found) begin
              sts_next = STS_NOT_FOUND;
            end else begin
              cmd.remove = 1'b1;
              occ_next   = occ - CNT_W'(1);
            end
          end
          default: ; // unused code: no change, done
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // count is the occupancy taken to the low seven bits
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (state == ST_APPLY) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q  <= op_t'(req.opcode);
      val_q <= req.value;
    end
    if (state == ST_APPLY) begin
      rsp_status <= sts_next;
      rsp_count  <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign req.ready  = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.count  = rsp_count;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_occ_only_apply: assert property (@(posedge clk) disable iff (rst)
    (state != ST_APPLY) |=> $stable(occ))
    else $error("occupancy moved outside apply");

  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_APPLY))
    else $error("response raised without apply");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> !rsp_valid)
    else $error("pending response would be overwritten");

  a_step_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |=> (occ == $past(occ)) || (occ == $past(occ) + CNT_W'(1))
                            || (occ == $past(occ) - CNT_W'(1)))
    else $error("occupancy stepped by more than one");
`endif

endmodule

[design/olid_cell.sv]
// One storage cell of the list row: holds an entry and its compare hit.
// Depends on olid_pkg.
module olid_cell (
  input  logic                             clk,
  input  olid_pkg::cell_cmd_t              cmd,
  input  logic signed [olid_pkg::VAL_W-1:0] value,
  input  logic signed [olid_pkg::VAL_W-1:0] prev_entry,
  input  logic signed [olid_pkg::VAL_W-1:0] next_entry,
  input  logic                             live,
  input  logic                             tail,
  input  logic                             kill,
  output logic signed [olid_pkg::VAL_W-1:0] entry,
  output logic                             hit
);
  import olid_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      hit <= live && (entry == value);
    end
    if (cmd.front) begin
      entry <= prev_entry;
    end else if (cmd.append && tail) begin
      entry <= value;
    end else if (cmd.remove && kill) begin
      entry <= next_entry;
    end
  end

endmodule

[design/olid_prefix.sv]
// Inclusive prefix OR over the cell hit bits, log-depth.
// Depends on olid_pkg only by convention; no imported names used.
module olid_prefix #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0] hit,
  output logic [N-1:0] seen
);
  localparam int unsigned LV = $clog2(N);

  logic [N-1:0] lvl [LV+1];

  always_comb begin
    lvl[0] = hit;
    for (int k = 0; k < LV; k++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << k)) begin
          lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
        end else begin
          lvl[k+1][i] = lvl[k][i];
        end
      end
    end
  end

  assign seen = lvl[LV];

endmodule
